// ----- hw/rtl/mexp_pkg.sv -----
`default_nettype none

package mexp_pkg;

    // Operand width of the arithmetic; the stream fields are 32 bits wide.
    localparam int WORD_BITS = 32;
    localparam int CNT_BITS  = $clog2(WORD_BITS);

    localparam int CFG_INDEX_BITS = 2;

    typedef logic [WORD_BITS-1:0]      word_t;
    typedef logic [CNT_BITS-1:0]       cnt_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t CFG_EXPONENT = cfg_index_t'(0);
    localparam cfg_index_t CFG_MODULUS  = cfg_index_t'(1);

    localparam word_t EXPONENT_RESET = word_t'(65537);
    localparam word_t MODULUS_RESET  = '0;

    localparam cnt_t CNT_LAST = cnt_t'(WORD_BITS - 1);

    // Which register a modular product goes to.
    typedef enum logic {
        SEL_MUL = 1'b0,
        SEL_SQR = 1'b1
    } mm_sel_t;

    typedef struct packed {
        logic    load;
        logic    red_step;
        logic    mm_start;
        logic    mm_step;
        logic    mm_write;
        mm_sel_t mm_sel;
        logic    exp_shift;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic mod_zero;
        logic exp_bit;
        logic exp_zero;
        logic out_free;
    } status_t;

    // (x + y) mod m for y <= m; the sum never leaves the word.
    function automatic word_t add_mod(input word_t x, input word_t y, input word_t m);
        word_t gap;
        gap = m - y;
        if (x >= gap) begin
            return x - gap;
        end
        return x + y;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mexp_ctrl.sv -----
`default_nettype none

module mexp_ctrl
    import mexp_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    start,
    input  wire status_t status,
    output logic         idle,
    output cmd_t         cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_REDUCE = 6'b000010,
        S_CHECK  = 6'b000100,
        S_MUL    = 6'b001000,
        S_SQRSET = 6'b010000,
        S_SQR    = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    cnt_t   cnt_reg, cnt_next;
    logic   done_reg, done_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // done_reg marks an item that is finished and waits for the output slot.
    assign idle = (state_reg == S_IDLE) && !done_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = done_reg;
        cmd        = '0;
        cmd.mm_sel = SEL_MUL;
        case (state_reg)
            S_IDLE: begin
                if (done_reg) begin
                    if (status.out_free) begin
                        cmd.out_load = 1'b1;
                        done_next    = 1'b0;
                    end
                end else if (start) begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    if (status.mod_zero) begin
                        done_next = 1'b1;
                    end else begin
                        state_next = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                cmd.red_step = 1'b1;
                cnt_next     = cnt_reg + cnt_t'(1);
                if (cnt_reg == CNT_LAST) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cnt_next = '0;
                if (status.exp_zero) begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end else if (status.exp_bit) begin
                    cmd.mm_start = 1'b1;
                    cmd.mm_sel   = SEL_MUL;
                    state_next   = S_MUL;
                end else begin
                    cmd.mm_start = 1'b1;
                    cmd.mm_sel   = SEL_SQR;
                    state_next   = S_SQR;
                end
            end
            S_MUL: begin
                cmd.mm_step = 1'b1;
                cmd.mm_sel  = SEL_MUL;
                cnt_next    = cnt_reg + cnt_t'(1);
                if (cnt_reg == CNT_LAST) begin
                    cmd.mm_write = 1'b1;
                    state_next   = S_SQRSET;
                end
            end
            S_SQRSET: begin
                cmd.mm_start = 1'b1;
                cmd.mm_sel   = SEL_SQR;
                cnt_next     = '0;
                state_next   = S_SQR;
            end
            S_SQR: begin
                cmd.mm_step = 1'b1;
                cmd.mm_sel  = SEL_SQR;
                cnt_next    = cnt_reg + cnt_t'(1);
                if (cnt_reg == CNT_LAST) begin
                    cmd.mm_write  = 1'b1;
                    cmd.exp_shift = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            default: begin
                state_next = S_IDLE;
                done_next  = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mexp_dp.sv -----
`default_nettype none

module mexp_dp
    import mexp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cmd_t       cmd,
    output status_t         status,
    input  wire logic       cfg_write,
    input  wire cfg_index_t cfg_index,
    input  wire word_t      cfg_data,
    input  wire word_t      in_base,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output word_t           out_power,
    output logic            out_last
);

    word_t exp_reg, mod_reg;
    word_t ebits_reg, ebits_next;
    word_t base_reg, base_next;
    word_t acc_reg, acc_next;
    word_t mm_a_reg, mm_a_next;
    word_t mm_b_reg, mm_b_next;
    word_t mm_acc_reg, mm_acc_next;
    logic  last_reg, last_next;
    word_t out_power_reg, out_power_next;
    logic  out_last_reg, out_last_next;
    logic  out_valid_reg, out_valid_next;

    logic [WORD_BITS:0] rem_shift;
    word_t              rem_step;
    word_t              mm_dbl;
    word_t              mm_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_reg <= EXPONENT_RESET;
            mod_reg <= MODULUS_RESET;
        end else if (cfg_write) begin
            if (cfg_index == CFG_EXPONENT) begin
                exp_reg <= cfg_data;
            end else if (cfg_index == CFG_MODULUS) begin
                mod_reg <= cfg_data;
            end
        end
    end

    // One restoring remainder step per cycle for the base reduction.
    always_comb begin
        rem_shift = {base_reg, mm_b_reg[WORD_BITS-1]};
        if (rem_shift >= {1'b0, mod_reg}) begin
            rem_shift = rem_shift - {1'b0, mod_reg};
        end
        rem_step = rem_shift[WORD_BITS-1:0];
    end

    // One bit of the shift-and-add modular multiply per cycle.
    always_comb begin
        mm_dbl = add_mod(mm_acc_reg, mm_acc_reg, mod_reg);
        mm_sum = mm_b_reg[WORD_BITS-1] ? add_mod(mm_dbl, mm_a_reg, mod_reg) : mm_dbl;
    end

    always_comb begin
        ebits_next     = ebits_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        mm_a_next      = mm_a_reg;
        mm_b_next      = mm_b_reg;
        mm_acc_next    = mm_acc_reg;
        last_next      = last_reg;
        out_power_next = out_power_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.load) begin
            ebits_next = exp_reg;
            base_next  = '0;
            acc_next   = word_t'(1);
            mm_b_next  = in_base;
            last_next  = in_last;
        end
        if (cmd.red_step) begin
            base_next = rem_step;
            mm_b_next = {mm_b_reg[WORD_BITS-2:0], 1'b0};
        end
        if (cmd.mm_start) begin
            mm_acc_next = '0;
            mm_b_next   = base_reg;
            mm_a_next   = (cmd.mm_sel == SEL_MUL) ? acc_reg : base_reg;
        end
        if (cmd.mm_step) begin
            mm_acc_next = mm_sum;
            mm_b_next   = {mm_b_reg[WORD_BITS-2:0], 1'b0};
        end
        if (cmd.mm_write) begin
            if (cmd.mm_sel == SEL_MUL) begin
                acc_next = mm_sum;
            end else begin
                base_next = mm_sum;
            end
        end
        if (cmd.exp_shift) begin
            ebits_next = {1'b0, ebits_reg[WORD_BITS-1:1]};
        end
        if (cmd.out_load) begin
            out_power_next = (mod_reg == '0) ? '0 : acc_reg;
            out_last_next  = last_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        ebits_reg     <= ebits_next;
        base_reg      <= base_next;
        acc_reg       <= acc_next;
        mm_a_reg      <= mm_a_next;
        mm_b_reg      <= mm_b_next;
        mm_acc_reg    <= mm_acc_next;
        last_reg      <= last_next;
        out_power_reg <= out_power_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.mod_zero = (mod_reg == '0);
    assign status.exp_bit  = ebits_reg[0];
    assign status.exp_zero = (ebits_reg == '0);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_power = out_power_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/modular_exponentiation.sv -----
`default_nettype none

// Channel   Direction  Handshake              Contents
// s_        in         s_tvalid / s_tready    base_value word, last_in on s_tlast
// m_        out        m_tvalid / m_tready    power_result word, last_out on m_tlast
// cfg_      in         cfg_valid / cfg_ready  register index and 32-bit write data
//
// Each word is first reduced by the modulus, then worked through one exponent bit
// at a time up to the exponent's highest one bit: a one bit takes a multiply and a
// square, a zero bit a square only. A single multiplier, one multiplier bit per
// cycle, does all of this. A zero modulus skips the work and gives a zero result.
// Reset is synchronous and active low; it restores the exponent to 65537 and the
// modulus to zero. A result waits in the output register while the next word goes in.

module modular_exponentiation
    import mexp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,    // [31:0] base_value
    input  wire logic        s_tlast,    // last_in

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,    // [31:0] power_result
    output logic             m_tlast,    // last_out

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire cfg_index_t  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cmd_t    cmd;
    status_t status;
    logic    idle;
    word_t   out_power;

    // Register writes are taken only while no word is being worked on, since the
    // modulus is used all through an exponentiation.
    assign cfg_ready = idle;

    // A new word is taken only while the controller is idle and no finished
    // result is stuck ahead of the output register. A pending register write
    // goes first, so that a word never starts on the edge of a key change.
    assign s_tready = idle && !cfg_valid;

    mexp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_tvalid && !cfg_valid),
        .status  (status),
        .idle    (idle),
        .cmd     (cmd)
    );

    mexp_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (word_t'(cfg_data)),
        .in_base   (word_t'(s_tdata)),
        .in_last   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_power (out_power),
        .out_last  (m_tlast)
    );

    assign m_tdata = 32'(out_power);

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`default_nettype none

// Self-checking bench for the modular exponentiation unit. Every accepted base
// word is run through a square-and-multiply model that tracks the exponent
// and modulus registers. The checker compares each result word against the
// oldest pending prediction.

module tb;
    import mexp_pkg::*;

    // Registers 2 and 3 do not exist. A write to either must leave both keys alone.
    localparam cfg_index_t CFG_SPARE_2 = cfg_index_t'(2);
    localparam cfg_index_t CFG_SPARE_3 = cfg_index_t'(3);

    // This is the watchdog's limit on the whole run.
    localparam int LIMIT_CYCLES = 3_000_000;
    // This wait covers the worst case for one word: a full 32-bit exponent plus the base reduction.
    localparam int DRAIN_CYCLES = 2200;

    typedef struct {
        word_t power;
        logic  last;
    } power_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_index_t  cfg_index;
    logic [31:0] cfg_data;

    // These are copies of the two key registers, as the block should hold them.
    word_t key_exponent;
    word_t key_modulus;

    power_word_t pending_powers[$];

    int error_count;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;
    int sink_hold_cycles;

    modular_exponentiation dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Right-to-left square-and-multiply. Both factors stay below the modulus, but for
    // the initial 1 with a modulus of 1, so a plain 64-bit product followed by a
    // remainder gives the same value as the block's bit-serial multiplier. When the
    // exponent is zero the accumulator keeps its initial 1, even with a modulus of 1.
    function automatic word_t predict_power(input word_t base, input word_t exp_value,
                                            input word_t mod_value);
        logic [63:0] acc;
        logic [63:0] square;
        if (mod_value == '0) begin
            return '0;
        end
        acc    = 64'd1;
        square = base % mod_value;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (exp_value[i]) begin
                acc = (acc * square) % mod_value;
            end
            square = (square * square) % mod_value;
        end
        return acc[WORD_BITS-1:0];
    endfunction

    // Offers one base word, with random idle cycles in front of it. The prediction
    // is queued at the edge where the block takes the word. tvalid stays high on
    // return, so that a following word can go out back to back.
    task automatic send_word(input word_t base, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= base;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        pending_powers.push_back('{predict_power(base, key_exponent, key_modulus), last});
    endtask

    // Stops offering words and waits until every predicted result has arrived.
    // The block holds nothing after that, so the key registers may change.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_powers.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // cfg_valid stays high on return. The caller lowers it after its last write.
    task automatic write_register(input cfg_index_t idx, input word_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_EXPONENT: key_exponent = value;
            CFG_MODULUS:  key_modulus  = value;
            default: ;
        endcase
    endtask

    // Every key change also includes one stray write to an index that does not
    // exist. That write carries random data, and the block must ignore it.
    task automatic set_registers(input bit load_exponent, input word_t exp_value,
                                 input bit load_modulus, input word_t mod_value);
        if (load_exponent) begin
            write_register(CFG_EXPONENT, exp_value);
        end
        if (load_modulus) begin
            write_register(CFG_MODULUS, mod_value);
        end
        write_register($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3, $urandom);
        cfg_valid <= 1'b0;
    endtask

    // After reset, the modulus is zero, so every result must be zero. Loading only
    // the modulus then shows that the exponent kept its reset value of 65537.
    task automatic test_reset_values();
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h1234_5678, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        wait_for_results();
        set_registers(1'b0, '0, 1'b1, 32'hFFFF_FFFB);
        send_word(32'h0000_0002, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        wait_for_results();
    endtask

    task automatic test_special_cases();
        // A zero exponent gives 1, and with a modulus of 1 the 1 is never reduced.
        set_registers(1'b1, 32'h0000_0000, 1'b1, 32'h0000_0001);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        wait_for_results();
        set_registers(1'b0, '0, 1'b1, 32'hFFFF_FFFF);
        send_word(32'h0000_0005, 1'b1);
        wait_for_results();
        // A zero modulus wins over a zero exponent, and over the largest exponent.
        set_registers(1'b0, '0, 1'b1, 32'h0000_0000);
        send_word(32'h0000_0007, 1'b1);
        wait_for_results();
        set_registers(1'b1, 32'hFFFF_FFFF, 1'b0, '0);
        send_word(32'hFFFF_FFFF, 1'b1);
        wait_for_results();
        // With a modulus of 1 and a nonzero exponent, the result reduces to zero.
        set_registers(1'b1, 32'h0000_0005, 1'b1, 32'h0000_0001);
        send_word(32'h0000_0003, 1'b1);
        wait_for_results();
        // Both keys are at their largest. A base equal to the modulus reduces to zero.
        set_registers(1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hFFFF_FFFE, 1'b0);
        send_word(32'h0000_0002, 1'b0);
        send_word(32'h0000_0001, 1'b1);
        wait_for_results();
        // With an exponent of 1, the result is just the reduced base.
        set_registers(1'b1, 32'h0000_0001, 1'b1, 32'h8000_0000);
        send_word(32'hDEAD_BEEF, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b1);
        wait_for_results();
        // Squaring minus one, modulo the modulus, gives 1.
        set_registers(1'b1, 32'h0000_0002, 1'b1, 32'hFFFF_FFFB);
        send_word(32'hFFFF_FFFA, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        wait_for_results();
    endtask

    // Random messages run under fourteen key settings. Most exponents are short, which
    // keeps the run quick, but some span all 32 bits and some are zero. A few
    // moduli are tiny, so that most bases start at or above them.
    task automatic test_random_messages();
        int    words_sent;
        int    msg_len;
        word_t exp_value;
        word_t mod_value;
        for (int phase = 0; phase < 14; phase++) begin
            if (phase < 5) begin
                send_idle_pct = 22;
                recv_idle_pct = 80;
            end else if (phase < 10) begin
                send_idle_pct = 80;
                recv_idle_pct = 22;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(9))
                0:       exp_value = $urandom;
                1:       exp_value = '0;
                default: exp_value = $urandom & ((32'h1 << $urandom_range(12, 1)) - 1);
            endcase
            mod_value = ($urandom_range(5) == 0) ? word_t'($urandom_range(255)) : $urandom;
            set_registers(1'b1, exp_value, 1'b1, mod_value);
            words_sent = 0;
            while (words_sent < 15) begin
                msg_len = $urandom_range(8, 1);
                for (int k = 0; k < msg_len; k++) begin
                    send_word(($urandom_range(7) == 0) ? word_t'($urandom_range(3)) : $urandom,
                              k == msg_len - 1);
                end
                words_sent += msg_len;
            end
            wait_for_results();
        end
    endtask

    // The sink stalls long enough that both the output register and the working
    // slot fill up. The input then has to push back on the source. After that,
    // the source goes quiet until everything has drained, and then it resumes.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_registers(1'b1, 32'h0000_0003, 1'b1, $urandom | 32'h1);
        sink_hold_cycles = 3000;
        for (int k = 0; k < 10; k++) begin
            send_word($urandom, k == 9);
        end
        wait_for_results();
        for (int k = 0; k < 5; k++) begin
            send_word($urandom, k == 4);
        end
        wait_for_results();
    endtask

    // This is the result checker. Everything is sampled at the rising edge,
    // before any nonblocking update, so a word counts exactly when the block
    // sees the handshake.
    initial begin : result_checker
        power_word_t want;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending_powers.size() == 0) begin
                    $error("unexpected result word: power_result %h last_out %b",
                           m_tdata, m_tlast);
                    error_count++;
                end else begin
                    want = pending_powers.pop_front();
                    if (m_tdata !== want.power) begin
                        $error("power_result: expected %h, got %h", want.power, m_tdata);
                        error_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_out: expected %b, got %b", want.last, m_tlast);
                        error_count++;
                    end
                end
            end
            if (sink_hold_cycles > 0) begin
                sink_hold_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // This is the watchdog. A hung handshake ends the run here.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        error_count      = 0;
        sink_hold_cycles = 0;
        send_idle_pct    = 22;
        recv_idle_pct    = 80;
        key_exponent     = EXPONENT_RESET;
        key_modulus      = MODULUS_RESET;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_EXPONENT;
        cfg_data  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_special_cases();
        test_random_messages();
        test_backpressure();

        // Any stray word that shows up late is flagged by the checker.
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
